[design/interleaved_rtp_deframer_macros.svh]
// ----------------------------------------------------------------------------
// Interleaved RTP deframer assertion macros
// Shared concurrent assertion forms used by the deframer modules.
// ----------------------------------------------------------------------------
`ifndef INTERLEAVED_RTP_DEFRAMER_MACROS_SVH
`define INTERLEAVED_RTP_DEFRAMER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define IRDF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define IRDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/irdf_pkg.sv]
// ----------------------------------------------------------------------------
// Interleaved RTP deframer package
// Types, codes and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package irdf_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [18:0] RTP_FIXED_HEADER_BYTES = 19'd12;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_BC_ENABLED = 2'd0;
    localparam logic [1:0] REG_BC_CHANNEL = 2'd1;
    localparam logic [1:0] REG_MAX_HEADER = 2'd2;

    localparam logic       RST_BC_ENABLED = 1'b0;
    localparam logic [7:0] RST_BC_CHANNEL = 8'd4;
    localparam logic [13:0] RST_MAX_HEADER = 14'd8192;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CHAN,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_HEADER
    } phase_t;

    typedef enum logic [1:0] {
        TP_NONE,
        TP_CR,
        TP_CRLF,
        TP_CRLFCR
    } term_t;

    typedef enum logic [1:0] {
        KIND_AUDIO,
        KIND_TEXT,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } push_t;

    typedef struct packed {
        logic        enabled;
        logic [7:0]  channel;
        logic [13:0] max_hdr;
    } cfg_t;

endpackage

[design/interleaved_rtp_deframer.sv]
// ----------------------------------------------------------------------------
// Interleaved RTP deframer
// Splits an RTSP control byte stream into backchannel audio and request text.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (rx_valid / rx_stall / rx_byte) takes one connection byte per
//   request. res channel (res_valid / res_stall / out_byte, out_kind,
//   last_of_item) delivers zero or one result per byte, in order.
//   Configuration goes through the APB-style port: enable at 0x0, channel at
//   0x4, header limit at 0x8; write only while the block is idle.
// Latency and throughput: a byte is parsed in the cycle it is accepted; if
//   the queue holds no older result, its result is visible on res_valid the
//   next cycle. One byte per cycle is taken while the queue is not full: the
//   parser state updates per byte; results pass a queue of QUEUE_DEPTH entries.
// Stall behavior: when the receiver holds res_stall, results pile up in the
//   queue; rx_stall rises only once the queue is full and drops as soon as
//   one entry drains.
// Reset: rst_n clears the parser to the item boundary, empties the queue,
//   revives a dead connection and loads the register reset values.
// ----------------------------------------------------------------------------
module interleaved_rtp_deframer
#(
    parameter int QUEUE_DEPTH = irdf_pkg::QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [irdf_pkg::ADDR_W-1:0] paddr,
    input  logic [irdf_pkg::DATA_W-1:0] pwdata,
    output logic [irdf_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // Byte input channel
    input  logic                        rx_valid,
    output logic                        rx_stall,
    input  logic [7:0]                  rx_byte,
    // Result channel
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [7:0]                  out_byte,
    output logic [1:0]                  out_kind,
    output logic                        last_of_item
);

    logic              enabled_reg, enabled_next;
    logic [7:0]        channel_reg, channel_next;
    logic [13:0]       max_hdr_reg, max_hdr_next;
    logic [1:0]        reg_index;
    logic              cfg_write;

    irdf_pkg::cfg_t    cfg;
    irdf_pkg::push_t   push;
    irdf_pkg::result_t head;
    logic              q_full;
    logic              accept;
    logic              pop;

    // Register file: the word index picks the register, others are ignored
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        enabled_next = enabled_reg;
        channel_next = channel_reg;
        max_hdr_next = max_hdr_reg;
        if (cfg_write)
        begin
            case (reg_index)
                irdf_pkg::REG_BC_ENABLED: enabled_next = pwdata[0];
                irdf_pkg::REG_BC_CHANNEL: channel_next = pwdata[7:0];
                irdf_pkg::REG_MAX_HEADER: max_hdr_next = pwdata[13:0];
                default:                  enabled_next = enabled_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            irdf_pkg::REG_BC_ENABLED: prdata = {31'd0, enabled_reg};
            irdf_pkg::REG_BC_CHANNEL: prdata = {24'd0, channel_reg};
            irdf_pkg::REG_MAX_HEADER: prdata = {18'd0, max_hdr_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= irdf_pkg::RST_BC_ENABLED;
            channel_reg <= irdf_pkg::RST_BC_CHANNEL;
            max_hdr_reg <= irdf_pkg::RST_MAX_HEADER;
        end
        else
        begin
            enabled_reg <= enabled_next;
            channel_reg <= channel_next;
            max_hdr_reg <= max_hdr_next;
        end
    end

    assign cfg.enabled = enabled_reg;
    assign cfg.channel = channel_reg;
    assign cfg.max_hdr = max_hdr_reg;

    // Hold the input off only when the queue has no room
    assign rx_stall = q_full;
    assign accept   = rx_valid && !rx_stall;
    assign pop      = res_valid && !res_stall;

    irdf_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .cfg     (cfg),
        .push    (push)
    );

    irdf_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .full      (q_full),
        .out_valid (res_valid),
        .out_data  (head)
    );

    assign out_byte     = head.data;
    assign out_kind     = head.kind;
    assign last_of_item = head.last;

endmodule

[design/irdf_front.sv]
// ----------------------------------------------------------------------------
// Interleaved RTP deframer front end
// Parses one accepted byte per cycle and pushes at most one result.
// ----------------------------------------------------------------------------
`include "interleaved_rtp_deframer_macros.svh"

module irdf_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    input  irdf_pkg::cfg_t       cfg,
    output irdf_pkg::push_t      push
);

    irdf_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      length_reg, length_next;
    logic [15:0]      pos_reg, pos_next;
    logic             match_reg, match_next;
    logic [18:0]      offset_reg, offset_next;
    logic             ext_reg, ext_next;
    logic [7:0]       ext_hi_reg, ext_hi_next;
    irdf_pkg::term_t  term_reg, term_next;
    logic [13:0]      hdr_cnt_reg, hdr_cnt_next;
    logic             dead_reg, dead_next;

    // Header terminator tracking, shared by the idle and header phases
    irdf_pkg::term_t  tp_in, tp_new;
    logic [13:0]      cnt_in;
    logic             hdr_done;

    // Frame body helpers
    logic             body_last;
    logic [19:0]      pos_wide;
    logic [19:0]      off_plus2, off_plus3;
    logic [15:0]      ext_words;
    logic [15:0]      length_lo;

    always_comb
    begin
        tp_in  = (phase_reg == irdf_pkg::PH_IDLE) ? irdf_pkg::TP_NONE : term_reg;
        cnt_in = (phase_reg == irdf_pkg::PH_IDLE) ? 14'd0 : hdr_cnt_reg;
        hdr_done = 1'b0;
        if (rx_byte == irdf_pkg::CH_CR)
        begin
            tp_new = (tp_in == irdf_pkg::TP_CRLF) ? irdf_pkg::TP_CRLFCR : irdf_pkg::TP_CR;
        end
        else if (rx_byte == irdf_pkg::CH_LF)
        begin
            if (tp_in == irdf_pkg::TP_CR)
            begin
                tp_new = irdf_pkg::TP_CRLF;
            end
            else if (tp_in == irdf_pkg::TP_CRLFCR)
            begin
                tp_new   = tp_in;
                hdr_done = 1'b1;
            end
            else
            begin
                tp_new = irdf_pkg::TP_NONE;
            end
        end
        else
        begin
            tp_new = irdf_pkg::TP_NONE;
        end
    end

    assign pos_wide  = {4'd0, pos_reg};
    assign off_plus2 = {1'b0, offset_reg} + 20'd2;
    assign off_plus3 = {1'b0, offset_reg} + 20'd3;
    assign ext_words = {ext_hi_reg, rx_byte};
    assign length_lo = {length_reg[15:8], rx_byte};
    assign body_last = ({1'b0, pos_reg} + 17'd1) >= {1'b0, length_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        pos_next     = pos_reg;
        match_next   = match_reg;
        offset_next  = offset_reg;
        ext_next     = ext_reg;
        ext_hi_next  = ext_hi_reg;
        term_next    = term_reg;
        hdr_cnt_next = hdr_cnt_reg;
        dead_next    = dead_reg;
        push         = '0;

        if (accept && !dead_reg)
        begin
            case (phase_reg)
                irdf_pkg::PH_IDLE,
                irdf_pkg::PH_HEADER:
                begin
                    if ((phase_reg == irdf_pkg::PH_IDLE) && (rx_byte == irdf_pkg::CH_DOLLAR))
                    begin
                        phase_next = irdf_pkg::PH_CHAN;
                    end
                    else if (hdr_done)
                    begin
                        phase_next    = irdf_pkg::PH_IDLE;
                        term_next     = irdf_pkg::TP_NONE;
                        hdr_cnt_next  = 14'd0;
                        push.valid    = 1'b1;
                        push.res.data = rx_byte;
                        push.res.kind = irdf_pkg::KIND_TEXT;
                        push.res.last = 1'b1;
                    end
                    else if (cnt_in >= cfg.max_hdr)
                    begin
                        // Oversized header: flag and go dead
                        dead_next     = 1'b1;
                        phase_next    = irdf_pkg::PH_IDLE;
                        term_next     = tp_new;
                        hdr_cnt_next  = cnt_in;
                        push.valid    = 1'b1;
                        push.res.data = 8'd0;
                        push.res.kind = irdf_pkg::KIND_ERROR;
                        push.res.last = 1'b0;
                    end
                    else
                    begin
                        phase_next    = irdf_pkg::PH_HEADER;
                        term_next     = tp_new;
                        hdr_cnt_next  = cnt_in + 14'd1;
                        push.valid    = 1'b1;
                        push.res.data = rx_byte;
                        push.res.kind = irdf_pkg::KIND_TEXT;
                        push.res.last = 1'b0;
                    end
                end
                irdf_pkg::PH_CHAN:
                begin
                    match_next = cfg.enabled && (rx_byte == cfg.channel);
                    phase_next = irdf_pkg::PH_LEN_HI;
                end
                irdf_pkg::PH_LEN_HI:
                begin
                    length_next = {rx_byte, 8'd0};
                    phase_next  = irdf_pkg::PH_LEN_LO;
                end
                irdf_pkg::PH_LEN_LO:
                begin
                    length_next = length_lo;
                    pos_next    = 16'd0;
                    offset_next = irdf_pkg::RTP_FIXED_HEADER_BYTES;
                    ext_next    = 1'b0;
                    ext_hi_next = 8'd0;
                    phase_next  = (length_lo == 16'd0) ? irdf_pkg::PH_IDLE : irdf_pkg::PH_BODY;
                end
                irdf_pkg::PH_BODY:
                begin
                    if (match_reg)
                    begin
                        if (pos_reg == 16'd0)
                        begin
                            offset_next = irdf_pkg::RTP_FIXED_HEADER_BYTES
                                        + {13'd0, rx_byte[3:0], 2'b00};
                            ext_next    = rx_byte[4];
                        end
                        else if (ext_reg)
                        begin
                            if (pos_wide == off_plus2)
                            begin
                                ext_hi_next = rx_byte;
                            end
                            else if (pos_wide == off_plus3)
                            begin
                                offset_next = offset_reg + 19'd4 + {1'b0, ext_words, 2'b00};
                                ext_next    = 1'b0;
                            end
                        end
                        else if ({3'd0, pos_reg} >= offset_reg)
                        begin
                            push.valid    = 1'b1;
                            push.res.data = rx_byte;
                            push.res.kind = irdf_pkg::KIND_AUDIO;
                            push.res.last = body_last;
                        end
                    end
                    if (body_last)
                    begin
                        phase_next = irdf_pkg::PH_IDLE;
                        pos_next   = 16'd0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 16'd1;
                    end
                end
                default:
                begin
                    phase_next = irdf_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= irdf_pkg::PH_IDLE;
            length_reg  <= 16'd0;
            pos_reg     <= 16'd0;
            match_reg   <= 1'b0;
            offset_reg  <= irdf_pkg::RTP_FIXED_HEADER_BYTES;
            ext_reg     <= 1'b0;
            ext_hi_reg  <= 8'd0;
            term_reg    <= irdf_pkg::TP_NONE;
            hdr_cnt_reg <= 14'd0;
            dead_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            pos_reg     <= pos_next;
            match_reg   <= match_next;
            offset_reg  <= offset_next;
            ext_reg     <= ext_next;
            ext_hi_reg  <= ext_hi_next;
            term_reg    <= term_next;
            hdr_cnt_reg <= hdr_cnt_next;
            dead_reg    <= dead_next;
        end
    end

    `IRDF_ASSERT_SAME(a_dead_silent, clk, rst_n, dead_reg, !push.valid, "result after dead")
    `IRDF_ASSERT_SAME(a_body_nonzero, clk, rst_n, phase_reg == irdf_pkg::PH_BODY, length_reg != 16'd0, "body phase with zero length")

endmodule

[design/irdf_queue.sv]
// ----------------------------------------------------------------------------
// Interleaved RTP deframer result queue
// Small FIFO that decouples the parser from the result channel.
// ----------------------------------------------------------------------------
`include "interleaved_rtp_deframer_macros.svh"

module irdf_queue
#(
    parameter int DEPTH = irdf_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  irdf_pkg::push_t   push,
    input  logic              pop,
    output logic              full,
    output logic              out_valid,
    output irdf_pkg::result_t out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    irdf_pkg::result_t entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries_reg[wr_ptr_reg] <= push.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `IRDF_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count overflow")
    `IRDF_ASSERT_NEXT(a_count_drain, clk, rst_n, do_pop && !push.valid, count_reg == $past(count_reg) - CNT_W'(1), "queue count did not drop on pop")

endmodule

[test/interleaved_rtp_deframer_test.sv]
// ----------------------------------------------------------------------------
// Interleaved RTP deframer testbench
// Drives byte streams of interleaved RTP frames and request headers into the
// deframer, predicts every audio, text and error result with a local parser
// model and checks each delivered result against it, under random idling,
// receiver hold-off and several register settings.
// ----------------------------------------------------------------------------
module interleaved_rtp_deframer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    // Results leave through the queue after the byte is taken; allow some extra.
    localparam int SETTLE_CYCLES = irdf_pkg::QUEUE_DEPTH + 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int TIMEOUT_NS    = 2_000_000;

    // Register index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef logic [7:0] octets_t[$];

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [irdf_pkg::ADDR_W-1:0]   paddr        = '0;
    logic [irdf_pkg::DATA_W-1:0]   pwdata       = '0;
    logic [irdf_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          rx_valid     = 1'b0;
    logic                          rx_stall;
    logic [7:0]                    rx_byte      = '0;
    logic                          res_valid;
    logic                          res_stall    = 1'b0;
    logic [7:0]                    out_byte;
    logic [1:0]                    out_kind;
    logic                          last_of_item;

    // ------------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------------
    irdf_pkg::result_t awaited_out[$];  // results owed by the block, oldest first
    int          mismatches    = 0;
    int          bytes_sent    = 0;
    int          send_idle_pct = 0;  // chance in 100 of an idle cycle per request
    int          stall_pct     = 0;  // chance in 100 of a receiver stall cycle
    bit          hold_request  = 1'b0;

    // Parser model: registers
    logic        cfg_enabled   = irdf_pkg::RST_BC_ENABLED;
    logic [7:0]  cfg_channel   = irdf_pkg::RST_BC_CHANNEL;
    logic [13:0] cfg_max_hdr   = irdf_pkg::RST_MAX_HEADER;

    // Parser model: state
    irdf_pkg::phase_t parse_state = irdf_pkg::PH_IDLE;
    logic [15:0] frame_len     = '0;
    logic [15:0] frame_pos     = '0;
    logic        chan_hit      = 1'b0;
    logic [18:0] skip_bytes    = irdf_pkg::RTP_FIXED_HEADER_BYTES;
    logic        ext_pending   = 1'b0;
    logic [7:0]  ext_hi        = '0;
    irdf_pkg::term_t term_state = irdf_pkg::TP_NONE;
    logic [13:0] hdr_count     = '0;
    logic        conn_dead     = 1'b0;

    interleaved_rtp_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .out_byte     (out_byte),
        .out_kind     (out_kind),
        .last_of_item (last_of_item)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Parser model: advance on one accepted byte and queue the result it owes
    // ------------------------------------------------------------------------
    task automatic parse_rx_byte(input logic [7:0] b);
        irdf_pkg::result_t r;
        bit          owes;
        bit          in_header;
        bit          done;
        bit          is_last;
        int unsigned pos;
        owes      = 1'b0;
        in_header = 1'b0;
        done      = 1'b0;
        r         = '0;
        // A dead connection drops everything until reset.
        if (!conn_dead)
        begin
            case (parse_state)
                irdf_pkg::PH_IDLE:
                begin
                    if (b == irdf_pkg::CH_DOLLAR)
                        parse_state = irdf_pkg::PH_CHAN;
                    else
                    begin
                        // Any other byte at a boundary opens a request header.
                        parse_state = irdf_pkg::PH_HEADER;
                        term_state  = irdf_pkg::TP_NONE;
                        hdr_count   = '0;
                        in_header   = 1'b1;
                    end
                end
                irdf_pkg::PH_CHAN:
                begin
                    // Enable and channel are sampled on the channel byte only.
                    chan_hit    = cfg_enabled && (b == cfg_channel);
                    parse_state = irdf_pkg::PH_LEN_HI;
                end
                irdf_pkg::PH_LEN_HI:
                begin
                    frame_len   = {b, 8'h00};
                    parse_state = irdf_pkg::PH_LEN_LO;
                end
                irdf_pkg::PH_LEN_LO:
                begin
                    frame_len[7:0] = b;
                    frame_pos      = '0;
                    skip_bytes     = irdf_pkg::RTP_FIXED_HEADER_BYTES;
                    ext_pending    = 1'b0;
                    ext_hi         = '0;
                    // A zero-length frame goes straight back to the boundary.
                    parse_state    = (frame_len == 16'd0) ? irdf_pkg::PH_IDLE
                                                          : irdf_pkg::PH_BODY;
                end
                irdf_pkg::PH_BODY:
                begin
                    pos     = frame_pos;
                    is_last = (pos + 1) >= int'(frame_len);
                    if (chan_hit)
                    begin
                        if (pos == 0)
                        begin
                            // CSRC count and X bit size the part to skip.
                            skip_bytes  = 19'(int'(irdf_pkg::RTP_FIXED_HEADER_BYTES)
                                              + 4 * int'(b[3:0]));
                            ext_pending = b[4];
                        end
                        else if (ext_pending)
                        begin
                            if (pos == int'(skip_bytes) + 2)
                                ext_hi = b;
                            else if (pos == int'(skip_bytes) + 3)
                            begin
                                skip_bytes  = 19'(int'(skip_bytes) + 4
                                                  + 4 * int'({ext_hi, b}));
                                ext_pending = 1'b0;
                            end
                        end
                        else if (pos >= int'(skip_bytes))
                        begin
                            r.data = b;
                            r.kind = irdf_pkg::KIND_AUDIO;
                            r.last = is_last;
                            owes   = 1'b1;
                        end
                    end
                    if (is_last)
                    begin
                        parse_state = irdf_pkg::PH_IDLE;
                        frame_pos   = '0;
                    end
                    else
                        frame_pos = 16'(pos + 1);
                end
                irdf_pkg::PH_HEADER:
                    in_header = 1'b1;
                default:
                    parse_state = irdf_pkg::PH_IDLE;
            endcase

            if (in_header)
            begin
                // Track progress through CR LF CR LF.
                if (b == irdf_pkg::CH_CR)
                    term_state = (term_state == irdf_pkg::TP_CRLF) ? irdf_pkg::TP_CRLFCR
                                                                   : irdf_pkg::TP_CR;
                else if (b == irdf_pkg::CH_LF)
                begin
                    if (term_state == irdf_pkg::TP_CR)
                        term_state = irdf_pkg::TP_CRLF;
                    else if (term_state == irdf_pkg::TP_CRLFCR)
                        done = 1'b1;
                    else
                        term_state = irdf_pkg::TP_NONE;
                end
                else
                    term_state = irdf_pkg::TP_NONE;

                owes = 1'b1;
                if (done)
                begin
                    parse_state = irdf_pkg::PH_IDLE;
                    term_state  = irdf_pkg::TP_NONE;
                    hdr_count   = '0;
                    r.data      = b;
                    r.kind      = irdf_pkg::KIND_TEXT;
                    r.last      = 1'b1;
                end
                else if (hdr_count >= cfg_max_hdr)
                begin
                    // Oversize: error replaces the byte and the connection dies.
                    conn_dead   = 1'b1;
                    parse_state = irdf_pkg::PH_IDLE;
                    r.data      = 8'h00;
                    r.kind      = irdf_pkg::KIND_ERROR;
                    r.last      = 1'b0;
                end
                else
                begin
                    hdr_count = hdr_count + 14'd1;
                    r.data    = b;
                    r.kind    = irdf_pkg::KIND_TEXT;
                    r.last    = 1'b0;
                end
            end
        end
        if (owes)
            awaited_out = {awaited_out, r};
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one request after a random idle gap; hold it until accepted.
    task automatic send_rx(input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (rx_stall);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    // Drop valid, wait for every owed result, then let the queue go quiet.
    task automatic settle();
        rx_valid <= 1'b0;
        while (awaited_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup phase, access phase, then an idle gap so writes never abut.
    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            irdf_pkg::REG_BC_ENABLED: cfg_enabled = value[0];
            irdf_pkg::REG_BC_CHANNEL: cfg_channel = value[7:0];
            irdf_pkg::REG_MAX_HEADER: cfg_max_hdr = value[13:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // RTP packet: fixed header, CSRC list, optional extension, payload.
    function automatic octets_t rtp_packet(input int unsigned cc, input bit ext,
                                           input int unsigned words,
                                           input int unsigned payload_len);
        octets_t    pkt;
        logic [7:0] lead;
        lead = {3'($urandom), ext, 4'(cc)};
        pkt  = {lead};
        repeat (11) pkt = {pkt, 8'($urandom)};
        repeat (4 * cc) pkt = {pkt, 8'($urandom)};
        if (ext)
        begin
            pkt = {pkt, 8'($urandom)};
            pkt = {pkt, 8'($urandom)};
            pkt = {pkt, 8'(words >> 8)};
            pkt = {pkt, 8'(words)};
            repeat (4 * words) pkt = {pkt, 8'($urandom)};
        end
        repeat (payload_len) pkt = {pkt, 8'($urandom)};
        return pkt;
    endfunction

    // Header text that can neither start a frame nor end the header early.
    function automatic octets_t request_body(input int unsigned n);
        octets_t     body;
        logic [7:0]  c;
        for (int i = 0; i < int'(n); i++)
        begin
            c = 8'($urandom);
            if ($urandom_range(9) < 3)
                c = $urandom_range(1) ? irdf_pkg::CH_CR : irdf_pkg::CH_LF;
            if (i == 0 && c == irdf_pkg::CH_DOLLAR)
                c = 8'h47;
            if (c == irdf_pkg::CH_LF && i >= 3 && body[i-3] == irdf_pkg::CH_CR
                && body[i-2] == irdf_pkg::CH_LF && body[i-1] == irdf_pkg::CH_CR)
                c = 8'h20;
            // A trailing CR LF would merge with the terminator.
            if (i == int'(n) - 1 && (c == irdf_pkg::CH_CR || c == irdf_pkg::CH_LF))
                c = 8'h3A;
            body = {body, c};
        end
        return body;
    endfunction

    // '$', channel, big-endian length, then len bytes (padded with noise).
    task automatic send_frame(input logic [7:0] channel, input octets_t pkt,
                              input int unsigned len);
        logic [15:0] len16;
        len16 = len[15:0];
        send_rx(irdf_pkg::CH_DOLLAR);
        send_rx(channel);
        send_rx(len16[15:8]);
        send_rx(len16[7:0]);
        for (int i = 0; i < int'(len); i++)
            send_rx(i < pkt.size() ? pkt[i] : 8'($urandom));
    endtask

    task automatic send_request(input octets_t body);
        foreach (body[i])
            send_rx(body[i]);
        send_rx(irdf_pkg::CH_CR);
        send_rx(irdf_pkg::CH_LF);
        send_rx(irdf_pkg::CH_CR);
        send_rx(irdf_pkg::CH_LF);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: backchannel off, so even channel 4 frames are dropped.
    task automatic test_reset_defaults();
        octets_t pkt;
        send_request('{8'h00, 8'hFF});
        pkt = rtp_packet(0, 1'b0, 0, 2);
        send_frame(irdf_pkg::RST_BC_CHANNEL, pkt, pkt.size());
        settle();
    endtask

    // Backchannel frames: skipping, short frames, foreign channels.
    task automatic test_backchannel_frames();
        octets_t pkt;
        apb_write(irdf_pkg::REG_BC_ENABLED, 32'd1);

        pkt = rtp_packet(0, 1'b0, 0, 3);
        send_frame(irdf_pkg::RST_BC_CHANNEL, pkt, pkt.size());
        // zero length frame, then a header right at the boundary
        send_frame(irdf_pkg::RST_BC_CHANNEL, pkt, 0);
        send_request('{8'h41});
        // header only, nothing left to emit
        send_frame(irdf_pkg::RST_BC_CHANNEL, pkt, 12);
        // full CSRC list plus one extension word
        pkt = rtp_packet(15, 1'b1, 1, 2);
        send_frame(irdf_pkg::RST_BC_CHANNEL, pkt, pkt.size());
        // extension header cut off by the length
        pkt = rtp_packet(0, 1'b1, 2, 4);
        send_frame(irdf_pkg::RST_BC_CHANNEL, pkt, 14);
        // payload offset beyond the frame end
        pkt = rtp_packet(3, 1'b0, 0, 4);
        send_frame(irdf_pkg::RST_BC_CHANNEL, pkt, 20);
        // not our channel: swallowed whole
        pkt = rtp_packet(0, 1'b0, 0, 4);
        send_frame(irdf_pkg::RST_BC_CHANNEL + 8'd1, pkt, pkt.size());
        settle();

        // channel extremes; a single payload byte is also the last one
        apb_write(irdf_pkg::REG_BC_CHANNEL, 32'd0);
        pkt = rtp_packet(0, 1'b0, 0, 1);
        send_frame(8'd0, pkt, pkt.size());
        settle();
        apb_write(irdf_pkg::REG_BC_CHANNEL, 32'd255);
        // writes to an unmapped index must not land anywhere
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        pkt = rtp_packet(0, 1'b0, 0, 0);
        pkt = {pkt, 8'hFF};
        pkt = {pkt, 8'h00};
        send_frame(8'd255, pkt, pkt.size());
        settle();

        // disabled again: the matching channel is dropped
        apb_write(irdf_pkg::REG_BC_ENABLED, 32'd0);
        send_frame(8'd255, pkt, pkt.size());
        settle();
        apb_write(irdf_pkg::REG_BC_ENABLED, 32'd1);
    endtask

    // A header that takes exactly the limit passes; stray CR/LF reset progress.
    task automatic test_header_limit();
        apb_write(irdf_pkg::REG_MAX_HEADER, 32'd8);
        send_request(request_body(5));
        send_request('{irdf_pkg::CH_CR, irdf_pkg::CH_CR, irdf_pkg::CH_LF,
                       irdf_pkg::CH_LF});
        settle();
    endtask

    // Mostly well-formed frames and headers, some broken frames and noise.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input bit en, input logic [7:0] ch,
                                       input logic [13:0] max_hdr, input int budget);
        octets_t     pkt;
        int          stop_at;
        int          pick;
        int unsigned cc;
        int unsigned len;
        settle();
        apb_write(irdf_pkg::REG_BC_ENABLED, {31'd0, en});
        apb_write(irdf_pkg::REG_BC_CHANNEL, {24'd0, ch});
        apb_write(irdf_pkg::REG_MAX_HEADER, {18'd0, max_hdr});
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        stop_at       = bytes_sent + budget;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                cc  = ($urandom_range(9) < 7) ? $urandom_range(2) : $urandom_range(15);
                pkt = rtp_packet(cc, $urandom_range(9) < 3, $urandom_range(2),
                                 $urandom_range(24));
                send_frame(($urandom_range(9) < 8) ? ch : 8'($urandom), pkt, pkt.size());
            end
            else if (pick < 80 && max_hdr >= 14'd3)
                send_request(request_body($urandom_range(0, (max_hdr - 3 < 24) ?
                                                             max_hdr - 3 : 24)));
            else if (pick < 93)
            begin
                // Random packet bytes: truncated or bogus RTP headers.
                pkt.delete();
                repeat (40) pkt = {pkt, 8'($urandom)};
                len = ($urandom_range(19) == 0) ? 256 + $urandom_range(40)
                                                : $urandom_range(40);
                send_frame($urandom_range(1) ? ch : 8'($urandom), pkt, len);
            end
            else
            begin
                pkt.delete();
                send_frame(8'($urandom), pkt, 0);
            end
        end
        settle();
    endtask

    // Receiver holds off long enough to fill the block and stall the sender.
    task automatic test_backpressure();
        octets_t pkt;
        send_idle_pct = 0;
        stall_pct     = 0;
        apb_write(irdf_pkg::REG_MAX_HEADER, 32'd8192);
        hold_request = 1'b1;
        repeat (4)
        begin
            send_request(request_body(12));
            pkt = rtp_packet(1, 1'b0, 0, 10);
            send_frame(cfg_channel, pkt, pkt.size());
        end
        // Pause the sender until everything owed has come out.
        settle();
        pkt = rtp_packet(0, 1'b1, 1, 8);
        send_frame(cfg_channel, pkt, pkt.size());
        send_request(request_body(6));
        settle();
    endtask

    // Oversize header kills the connection; later bytes and writes change nothing.
    task automatic test_oversize_dead();
        octets_t pkt;
        send_idle_pct = 38;
        stall_pct     = 38;
        apb_write(irdf_pkg::REG_MAX_HEADER, 32'd1);
        send_request('{8'h41});
        pkt = rtp_packet(0, 1'b0, 0, 6);
        send_frame(cfg_channel, pkt, pkt.size());
        settle();
        apb_write(irdf_pkg::REG_MAX_HEADER, 32'd16383);
        send_request(request_body(4));
        send_frame(cfg_channel, pkt, pkt.size());
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    initial
    begin : result_checker
        irdf_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
            begin
                if (awaited_out.size() == 0)
                begin
                    $error("unexpected result: out_byte %0h out_kind %0d last_of_item %0b",
                           out_byte, out_kind, last_of_item);
                    mismatches++;
                end
                else
                begin
                    want = awaited_out.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %0h, got %0h", want.data, out_byte);
                        mismatches++;
                    end
                    if (out_kind !== want.kind)
                    begin
                        $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
                        mismatches++;
                    end
                    if (last_of_item !== want.last)
                    begin
                        $error("last_of_item: expected %0b, got %0b", want.last,
                               last_of_item);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall generator: long hold-off on request, else random stalls
    // ------------------------------------------------------------------------
    initial
    begin : stall_driver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        #(TIMEOUT_NS);
        $display("interleaved_rtp_deframer test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_backchannel_frames();
        test_header_limit();
        test_random_traffic(0, 0, 1'b1, 8'd0, 14'd16383, 125);
        test_random_traffic(53, 0, 1'b1, 8'd255, irdf_pkg::RST_MAX_HEADER, 125);
        test_random_traffic(0, 53, 1'b1, 8'($urandom), 14'($urandom_range(3, 40)), 125);
        test_random_traffic(38, 38, $urandom_range(3) != 0, 8'($urandom),
                            14'($urandom_range(3, 60)), 125);
        test_backpressure();
        // Must stay last: only reset revives a dead connection.
        test_oversize_dead();

        if (mismatches == 0)
            $display("interleaved_rtp_deframer test passed");
        else
            $display("interleaved_rtp_deframer test failed");
        $finish;
    end

endmodule
